FILE: src/codebook_4bit_dot_product_macros.svh
// assertion macros for the codebook dot product block
`ifndef CODEBOOK_4BIT_DOT_PRODUCT_MACROS_SVH
`define CODEBOOK_4BIT_DOT_PRODUCT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, disabled in reset
`define CBDP_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("cbdp assertion failed");
// next-cycle implication, disabled in reset
`define CBDP_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("cbdp assertion failed");
`else
`define CBDP_ASSERT_IMP(label, ante, cons)
`define CBDP_ASSERT_NEXT(label, ante, cons)
`endif
`endif

FILE: src/cbdp_pkg.sv
// types, constants and the centroid lookup of the codebook dot product block
package cbdp_pkg;

   localparam int ReqDataWidth = 88;
   localparam int CsrAddrWidth = 6;
   localparam int CsrDataWidth = 64;
   localparam int CsrIndexWidth = 3;
   localparam int NumCentroidWords = 4;
   localparam int RoundShift = 18;

   localparam logic [CsrIndexWidth-1:0] RegCentroidWord0 = 3'd0;
   localparam logic [CsrIndexWidth-1:0] RegCentroidWord1 = 3'd1;
   localparam logic [CsrIndexWidth-1:0] RegCentroidWord2 = 3'd2;
   localparam logic [CsrIndexWidth-1:0] RegCentroidWord3 = 3'd3;
   localparam logic [CsrIndexWidth-1:0] RegBiasEnable = 3'd4;

   localparam logic signed [47:0] SumMax = {1'b0, {47{1'b1}}};
   localparam logic signed [47:0] SumMin = {1'b1, {47{1'b0}}};
   localparam logic [40:0] RoundHalf = 41'd1 << (RoundShift - 1);
   localparam logic signed [31:0] ResultMax = {1'b0, {31{1'b1}}};
   localparam logic signed [31:0] ResultMin = {1'b1, {31{1'b0}}};

   // one config word: four q1.14 entries, entry 0 lowest
   typedef logic [3:0][15:0] centroid_word_type;
   typedef centroid_word_type [NumCentroidWords-1:0] centroid_table_type;

   typedef struct packed {
      logic load;
      logic acc;
      logic mul_lo;
      logic mul_hi;
      logic round;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic last;
   } status_type;

   function automatic logic signed [15:0] centroid_lookup(centroid_table_type tbl,
                                                         logic [3:0] code);
      return signed'(tbl[code[3:2]][code[1:0]]);
   endfunction

endpackage

FILE: src/codebook_4bit_dot_product.sv
// top level of the 4-bit codebook dot product engine
//
//  channel   direction  handshake                 payload
//  req_      in         req_tvalid / req_tready   req_tdata (fields), req_tlast (last)
//  rsp_      out        rsp_tvalid / rsp_tready   rsp_tdata (dot_result), rsp_tuser (flag)
//  csr_      in         apb, pready tied high     64-bit words at byte address 8*index
//
//  an item without last is accepted with products registered, then accumulated
//  an item with last is accepted, then goes through accumulate, two 24x16 partial products of the sum
//  and norm, rounding add, then bias add and clip into the output register
//  a finished result waits in the output register; new items are accepted meanwhile and
//  only the next result stalls in its final cycle until the output register is free
//  synchronous reset clears the running sum, the configuration registers and the controller
module codebook_4bit_dot_product (
   input  logic                                 clock,
   input  logic                                 reset,
   // input items
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // [7:0] packed_codes, [23:8] activation_even, [39:24] activation_odd,
   // [55:40] row scale, [87:56] bias_value
   input  logic [cbdp_pkg::ReqDataWidth-1:0]    req_tdata,
   input  logic                                 req_tlast,
   // result items
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // [31:0] dot_result
   output logic [31:0]                          rsp_tdata,
   // [0] saturated
   output logic                                 rsp_tuser,
   // configuration
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [cbdp_pkg::CsrAddrWidth-1:0]    csr_paddr,
   input  logic [cbdp_pkg::CsrDataWidth-1:0]    csr_pwdata,
   output logic [cbdp_pkg::CsrDataWidth-1:0]    csr_prdata,
   output logic                                 csr_pready
);

   cbdp_pkg::cmd_type cmd;
   cbdp_pkg::status_type status;
   cbdp_pkg::centroid_table_type centroid_table;
   logic bias_enable;
   logic signed [31:0] dot_result;

   // register file for the codebook and bias switch
   cbdp_csr u_csr (
      .clock          (clock),
      .reset          (reset),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready),
      .centroid_table (centroid_table),
      .bias_enable    (bias_enable)
   );

   // sequencer
   cbdp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // arithmetic, fields unpacked from the item
   cbdp_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .packed_codes    (req_tdata[7:0]),
      .activation_even (req_tdata[23:8]),
      .activation_odd  (req_tdata[39:24]),
      .row_scale       (req_tdata[55:40]),
      .bias_value      (req_tdata[87:56]),
      .last            (req_tlast),
      .centroid_table  (centroid_table),
      .bias_enable     (bias_enable),
      .dot_result      (dot_result),
      .saturated       (rsp_tuser)
   );

   assign rsp_tdata = dot_result;

endmodule

FILE: src/cbdp_csr.sv
// configuration registers: centroid table and bias enable
module cbdp_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [cbdp_pkg::CsrAddrWidth-1:0]    csr_paddr,
   input  logic [cbdp_pkg::CsrDataWidth-1:0]    csr_pwdata,
   output logic [cbdp_pkg::CsrDataWidth-1:0]    csr_prdata,
   output logic                                 csr_pready,
   output cbdp_pkg::centroid_table_type         centroid_table,
   output logic                                 bias_enable
);

   cbdp_pkg::centroid_table_type centroid_ff;
   logic bias_enable_ff;
   logic [cbdp_pkg::CsrIndexWidth-1:0] index;
   logic write;

   assign index = csr_paddr[cbdp_pkg::CsrAddrWidth-1:3];
   assign write = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         centroid_ff <= '0;
         bias_enable_ff <= 1'b0;
      end else if (write) begin
         if (index == cbdp_pkg::RegBiasEnable) begin
            bias_enable_ff <= csr_pwdata[0];
         end else if (index < cbdp_pkg::RegBiasEnable) begin
            centroid_ff[index[1:0]] <= csr_pwdata;
         end
      end
   end

   always_comb begin
      unique case (index)
         cbdp_pkg::RegCentroidWord0: csr_prdata = centroid_ff[0];
         cbdp_pkg::RegCentroidWord1: csr_prdata = centroid_ff[1];
         cbdp_pkg::RegCentroidWord2: csr_prdata = centroid_ff[2];
         cbdp_pkg::RegCentroidWord3: csr_prdata = centroid_ff[3];
         cbdp_pkg::RegBiasEnable: csr_prdata = {{(cbdp_pkg::CsrDataWidth-1){1'b0}}, bias_enable_ff};
         default: csr_prdata = '0;
      endcase
   end

   assign centroid_table = centroid_ff;
   assign bias_enable = bias_enable_ff;

endmodule

FILE: src/cbdp_datapath.sv
// datapath: centroid products, saturating accumulator, split scaling, bias and clip
module cbdp_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  cbdp_pkg::cmd_type             cmd,
   output cbdp_pkg::status_type          status,
   input  logic [7:0]                    packed_codes,
   input  logic signed [15:0]            activation_even,
   input  logic signed [15:0]            activation_odd,
   input  logic [15:0]                   row_scale,
   input  logic signed [31:0]            bias_value,
   input  logic                          last,
   input  cbdp_pkg::centroid_table_type  centroid_table,
   input  logic                          bias_enable,
   output logic signed [31:0]            dot_result,
   output logic                          saturated
);

   logic signed [15:0] cent_even;
   logic signed [15:0] cent_odd;
   logic signed [31:0] prod_even_ff, prod_even_in;
   logic signed [31:0] prod_odd_ff, prod_odd_in;
   logic [15:0] norm_ff;
   logic signed [31:0] bias_ff;
   logic last_ff;
   logic signed [47:0] running_sum_ff, running_sum_in;
   logic signed [32:0] pair;
   logic signed [48:0] acc_sum;
   logic [39:0] lo_prod;
   logic [40:0] lo_rnd_ff, lo_rnd_in;
   logic signed [40:0] hi_prod_ff, hi_prod_in;
   logic signed [64:0] scaled;
   logic signed [46:0] rounded_ff, rounded_in;
   logic signed [47:0] biased;
   logic signed [31:0] dot_result_ff, dot_result_in;
   logic saturated_ff, saturated_in;

   assign cent_even = cbdp_pkg::centroid_lookup(centroid_table, packed_codes[3:0]);
   assign cent_odd = cbdp_pkg::centroid_lookup(centroid_table, packed_codes[7:4]);
   assign prod_even_in = activation_even * cent_even;
   assign prod_odd_in = activation_odd * cent_odd;

   // accumulate with clip at the 48-bit bounds; the round command clears the sum instead
   always_comb begin
      pair = 33'(prod_even_ff) + 33'(prod_odd_ff);
      acc_sum = 49'(running_sum_ff) + 49'(pair);
      if (cmd.round) begin
         running_sum_in = '0;
      end else if (acc_sum[48] != acc_sum[47]) begin
         running_sum_in = acc_sum[48] ? cbdp_pkg::SumMin : cbdp_pkg::SumMax;
      end else begin
         running_sum_in = acc_sum[47:0];
      end
   end

   // sum * norm in two halves, rounding offset folded into the low half
   assign lo_prod = running_sum_ff[23:0] * norm_ff;
   assign lo_rnd_in = {1'b0, lo_prod} + cbdp_pkg::RoundHalf;
   assign hi_prod_in = $signed(running_sum_ff[47:24]) * $signed({1'b0, norm_ff});

   assign scaled = $signed({hi_prod_ff, 24'b0}) + $signed({24'b0, lo_rnd_ff});
   assign rounded_in = scaled[64:cbdp_pkg::RoundShift];

   always_comb begin
      biased = 48'(rounded_ff) + (bias_enable ? 48'(bias_ff) : 48'sd0);
      if (biased[47:31] != {17{biased[47]}}) begin
         dot_result_in = biased[47] ? cbdp_pkg::ResultMin : cbdp_pkg::ResultMax;
         saturated_in = 1'b1;
      end else begin
         dot_result_in = biased[31:0];
         saturated_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_sum_ff <= '0;
      end else if (cmd.acc || cmd.round) begin
         running_sum_ff <= running_sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         prod_even_ff <= prod_even_in;
         prod_odd_ff <= prod_odd_in;
         norm_ff <= row_scale;
         bias_ff <= bias_value;
         last_ff <= last;
      end
      if (cmd.mul_lo) begin
         lo_rnd_ff <= lo_rnd_in;
      end
      if (cmd.mul_hi) begin
         hi_prod_ff <= hi_prod_in;
      end
      if (cmd.round) begin
         rounded_ff <= rounded_in;
      end
      if (cmd.emit) begin
         dot_result_ff <= dot_result_in;
         saturated_ff <= saturated_in;
      end
   end

   assign status.last = last_ff;
   assign dot_result = dot_result_ff;
   assign saturated = saturated_ff;

endmodule

FILE: src/cbdp_ctrl.sv
// controller: sequences load, accumulate, scale, round and emit
`include "codebook_4bit_dot_product_macros.svh"
module cbdp_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  cbdp_pkg::status_type  status,
   output cbdp_pkg::cmd_type     cmd
);

   typedef enum logic [5:0] {
      S_IDLE = 6'b000001,
      S_ACC  = 6'b000010,
      S_MLO  = 6'b000100,
      S_MHI  = 6'b001000,
      S_RND  = 6'b010000,
      S_FIN  = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic out_valid_ff, out_valid_in;

   always_comb begin
      cmd = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            cmd.load = req_tvalid;
            if (req_tvalid) state_in = S_ACC;
         end
         S_ACC: begin
            cmd.acc = 1'b1;
            state_in = status.last ? S_MLO : S_IDLE;
         end
         S_MLO: begin
            cmd.mul_lo = 1'b1;
            state_in = S_MHI;
         end
         S_MHI: begin
            cmd.mul_hi = 1'b1;
            state_in = S_RND;
         end
         S_RND: begin
            cmd.round = 1'b1;
            state_in = S_FIN;
         end
         S_FIN: begin
            cmd.emit = !out_valid_ff || rsp_tready;
            if (cmd.emit) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (cmd.emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = out_valid_ff;

   `CBDP_ASSERT_NEXT(a_accept_goes_acc, req_tvalid && req_tready, state_ff == S_ACC)
   `CBDP_ASSERT_NEXT(a_plain_item_back_idle, (state_ff == S_ACC) && !status.last, req_tready)
   `CBDP_ASSERT_NEXT(a_emit_shows_result, cmd.emit, rsp_tvalid)
   `CBDP_ASSERT_NEXT(a_full_output_holds_fin,
                     (state_ff == S_FIN) && rsp_tvalid && !rsp_tready,
                     (state_ff == S_FIN) && rsp_tvalid)
   `CBDP_ASSERT_IMP(a_scaling_blocks_input, (state_ff == S_MLO) || (state_ff == S_RND),
                    !req_tready && !cmd.emit)

endmodule
